// ===== src/mvm_pkg.sv =====
// Shared constants and types for the matrix-vector multiply engine.
`default_nettype none

package mvm_pkg;

  // Matrix dimensions and derived index widths.
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int COL_AW   = $clog2(MAX_COLS);
  localparam int WDEPTH   = MAX_ROWS * MAX_COLS;
  localparam int WADDR_W  = $clog2(WDEPTH);

  // Field widths.
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = 40;
  localparam int CNT_W   = 5;
  localparam int IDX_W   = 4;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 48;

  // Weight value after reset: 0.1 in Q4.12.
  localparam logic signed [VAL_W-1:0] WEIGHT_RESET = 16'sd410;

  // Input function codes.
  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_VECTOR = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } mvm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              wr_weight;
    logic              wr_vec;
    logic              issue;
    logic              first;
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
    logic              load_out;
    logic              last_row;
  } mvm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mvm_stat_t;

endpackage

`default_nettype wire

// ===== src/matrix_vector_multiply.sv =====
// Top level of the dense matrix-vector multiply engine.
//
// Input words either write one signed Q4.12 weight (tuser 0) or load one vector
// element at its column (tuser 1). A vector element with tlast set, whose column
// plus one equals the columns in use, starts the multiply; otherwise nothing is
// emitted. Weights read as 0.1 until written, and the vector keeps its contents
// between multiplies. A multiply walks each row through one shared
// multiply-accumulate unit: one term per cycle, then the memory read, multiply
// and accumulate stages draining, then the sum is handed to the output
// register once it is free. No input word is taken during a multiply. Results
// leave in row order as exact signed Q16.24 sums with tlast on the final row.
// The output register lets the engine take the next input word while the final
// result still waits to be taken.
`default_nettype none

module matrix_vector_multiply (
  input  wire                               clk,
  input  wire                               rst,
  // Input stream
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [mvm_pkg::S_DATA_W-1:0]      s_tdata,  // row[3:0], col[7:4], value[23:8]
  input  wire                               s_tuser,  // func[0]
  input  wire                               s_tlast,
  // Result stream
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [mvm_pkg::M_DATA_W-1:0]      m_tdata,  // row_index[3:0], product[43:4], zero[47:44]
  output logic                              m_tlast,
  // Configuration writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire                               cfg_index,
  input  wire  [mvm_pkg::CNT_W-1:0]         cfg_data
);

  mvm_pkg::mvm_cmd_t               cmd;
  mvm_pkg::mvm_stat_t              stat;
  logic [mvm_pkg::IDX_W-1:0]       row_in;
  logic [mvm_pkg::IDX_W-1:0]       col_in;
  logic signed [mvm_pkg::VAL_W-1:0] value_in;
  logic [mvm_pkg::IDX_W-1:0]       row_index;
  logic signed [mvm_pkg::ACC_W-1:0] product;

  // Unpack the input word.
  assign row_in   = s_tdata[3:0];
  assign col_in   = s_tdata[7:4];
  assign value_in = s_tdata[23:8];

  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .func      (s_tuser),
    .last      (s_tlast),
    .col_in    (col_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  mvm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .row_in    (row_in),
    .col_in    (col_in),
    .value_in  (value_in),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .row_index (row_index),
    .product   (product),
    .last_row  (m_tlast)
  );

  // Pack the result word.
  assign m_tdata = {4'b0000, product, row_index};

endmodule

`default_nettype wire

// ===== src/mvm_ctrl.sv =====
// Controller state machine: sequences weight and vector writes and the row walk.
`default_nettype none

module mvm_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  // Input handshake and the fields that steer control
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire                          func,
  input  wire                          last,
  input  wire  [mvm_pkg::IDX_W-1:0]    col_in,
  // Configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_index,
  input  wire  [mvm_pkg::CNT_W-1:0]    cfg_data,
  // Datapath link
  output mvm_pkg::mvm_cmd_t            cmd,
  input  wire mvm_pkg::mvm_stat_t      stat
);

  mvm_pkg::mvm_state_t state, state_next;

  logic [mvm_pkg::CNT_W-1:0]  rows_in_use;
  logic [mvm_pkg::CNT_W-1:0]  cols_in_use;
  logic [mvm_pkg::CNT_W-1:0]  nrows;
  logic [mvm_pkg::CNT_W-1:0]  ncols;
  logic [mvm_pkg::ROW_AW-1:0] r_cnt;
  logic [mvm_pkg::COL_AW-1:0] c_cnt;
  logic                       accept;
  logic                       start;
  logic                       col_last;
  logic                       row_last;

  // Configuration registers; writes are taken whenever the block is out of reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mvm_pkg::CNT_W'(mvm_pkg::MAX_ROWS);
      cols_in_use <= mvm_pkg::CNT_W'(mvm_pkg::MAX_COLS);
    end else if (cfg_valid) begin
      case (cfg_index)
        mvm_pkg::CFG_ROWS: rows_in_use <= cfg_data;
        mvm_pkg::CFG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective counts: zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    if (rows_in_use == '0) begin
      nrows = mvm_pkg::CNT_W'(1);
    end else if (32'(rows_in_use) > mvm_pkg::MAX_ROWS) begin
      nrows = mvm_pkg::CNT_W'(mvm_pkg::MAX_ROWS);
    end else begin
      nrows = rows_in_use;
    end
    if (cols_in_use == '0) begin
      ncols = mvm_pkg::CNT_W'(1);
    end else if (32'(cols_in_use) > mvm_pkg::MAX_COLS) begin
      ncols = mvm_pkg::CNT_W'(mvm_pkg::MAX_COLS);
    end else begin
      ncols = cols_in_use;
    end
  end

  // A multiply starts on a last vector element whose position closes the vector.
  assign accept   = s_tvalid && s_tready;
  assign start    = accept && (func == mvm_pkg::FUNC_VECTOR) && last &&
                    ((mvm_pkg::CNT_W'(col_in) + mvm_pkg::CNT_W'(1)) == ncols);
  assign col_last = (mvm_pkg::CNT_W'(c_cnt) + mvm_pkg::CNT_W'(1)) == ncols;
  assign row_last = (mvm_pkg::CNT_W'(r_cnt) + mvm_pkg::CNT_W'(1)) == nrows;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mvm_pkg::ST_IDLE: begin
        if (start) state_next = mvm_pkg::ST_CALC;
      end
      mvm_pkg::ST_CALC: begin
        if (col_last) state_next = mvm_pkg::ST_DRAIN;
      end
      mvm_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = mvm_pkg::ST_EMIT;
      end
      mvm_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_next = row_last ? mvm_pkg::ST_IDLE : mvm_pkg::ST_CALC;
        end
      end
      default: state_next = mvm_pkg::ST_IDLE;
    endcase
  end

  // Row and column counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else begin
      case (state)
        mvm_pkg::ST_IDLE: begin
          r_cnt <= '0;
          c_cnt <= '0;
        end
        mvm_pkg::ST_CALC: begin
          c_cnt <= col_last ? '0 : c_cnt + mvm_pkg::COL_AW'(1);
        end
        mvm_pkg::ST_EMIT: begin
          if (stat.out_free && !row_last) r_cnt <= r_cnt + mvm_pkg::ROW_AW'(1);
        end
        default: ;
      endcase
    end
  end

  // Outputs.
  always_comb begin
    s_tready      = (state == mvm_pkg::ST_IDLE) && !rst;
    cmd.wr_weight = accept && (func == mvm_pkg::FUNC_WEIGHT);
    cmd.wr_vec    = accept && (func == mvm_pkg::FUNC_VECTOR);
    cmd.issue     = (state == mvm_pkg::ST_CALC);
    cmd.first     = (c_cnt == '0);
    cmd.row       = r_cnt;
    cmd.col       = c_cnt;
    cmd.load_out  = (state == mvm_pkg::ST_EMIT) && stat.out_free;
    cmd.last_row  = row_last;
  end

  // A term is only issued for a column in use.
  assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (mvm_pkg::CNT_W'(c_cnt) < ncols))
    else $error("column issued beyond the columns in use");

  // A result is loaded only once the multiply-accumulate pipe has drained.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !stat.pipe_busy)
    else $error("result loaded while terms were still in flight");

  // After the final row is handed over, the engine is back to taking words.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.last_row) |=> (state == mvm_pkg::ST_IDLE))
    else $error("engine did not return to idle after the final row");

  // Rows stay within the rows in use while results are produced.
  assert property (@(posedge clk) disable iff (rst)
    (state == mvm_pkg::ST_EMIT) |-> (mvm_pkg::CNT_W'(r_cnt) < nrows))
    else $error("row counter ran past the rows in use");

endmodule

`default_nettype wire

// ===== src/mvm_dp.sv =====
// Datapath: weight memory, vector store, multiply-accumulate pipe and output register.
`default_nettype none

module mvm_dp (
  input  wire                                clk,
  input  wire                                rst,
  // Input payload
  input  wire  [mvm_pkg::IDX_W-1:0]          row_in,
  input  wire  [mvm_pkg::IDX_W-1:0]          col_in,
  input  wire  signed [mvm_pkg::VAL_W-1:0]   value_in,
  // Controller link
  input  wire mvm_pkg::mvm_cmd_t             cmd,
  output mvm_pkg::mvm_stat_t                 stat,
  // Result channel
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [mvm_pkg::IDX_W-1:0]          row_index,
  output logic signed [mvm_pkg::ACC_W-1:0]   product,
  output logic                               last_row
);

  logic signed [mvm_pkg::VAL_W-1:0] wmem [mvm_pkg::WDEPTH];
  logic [mvm_pkg::WDEPTH-1:0]       wvalid;
  logic signed [mvm_pkg::VAL_W-1:0] vec [mvm_pkg::MAX_COLS];

  logic [mvm_pkg::WADDR_W-1:0]      waddr;
  logic [mvm_pkg::WADDR_W-1:0]      raddr;
  logic                             w_in_range;

  logic signed [mvm_pkg::VAL_W-1:0]  w_rd;
  logic                              w_rd_vld;
  logic signed [mvm_pkg::VAL_W-1:0]  x_rd;
  logic signed [mvm_pkg::VAL_W-1:0]  w_eff;
  logic                              s1_valid;
  logic                              s1_first;
  logic signed [mvm_pkg::PROD_W-1:0] prod;
  logic                              s2_valid;
  logic                              s2_first;
  logic signed [mvm_pkg::ACC_W-1:0]  acc;

  // Address decode for writes and reads.
  assign w_in_range = (32'(row_in) < mvm_pkg::MAX_ROWS) && (32'(col_in) < mvm_pkg::MAX_COLS);
  assign waddr = mvm_pkg::WADDR_W'(32'(row_in) * mvm_pkg::MAX_COLS + 32'(col_in));
  assign raddr = mvm_pkg::WADDR_W'(32'(cmd.row) * mvm_pkg::MAX_COLS + 32'(cmd.col));

  // Weight memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_weight && w_in_range) begin
      wmem[waddr] <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      w_rd <= wmem[raddr];
    end
  end

  // Written marks: an entry never written reads as the reset weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else if (cmd.wr_weight && w_in_range) begin
      wvalid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      w_rd_vld <= wvalid[raddr];
    end
  end

  // Vector store, read at the issued column.
  always_ff @(posedge clk) begin
    if (cmd.wr_vec && (32'(col_in) < mvm_pkg::MAX_COLS)) begin
      vec[col_in[mvm_pkg::COL_AW-1:0]] <= value_in;
    end
    if (cmd.issue) begin
      x_rd <= vec[cmd.col];
    end
  end

  assign w_eff = w_rd_vld ? w_rd : mvm_pkg::WEIGHT_RESET;

  // Pipe tags follow each issued term.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.first;
    s2_first <= s1_first;
  end

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prod <= w_eff * x_rd;
    end
  end

  // Accumulate stage; the first term of a row restarts the sum.
  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= s2_first ? mvm_pkg::ACC_W'(prod) : acc + mvm_pkg::ACC_W'(prod);
    end
  end

  // Output register holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      row_index <= mvm_pkg::IDX_W'(cmd.row);
      product   <= acc;
      last_row  <= cmd.last_row;
    end
  end

  // Status back to the controller.
  assign stat.pipe_busy = s1_valid || s2_valid;
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire
